// ===== hw/rtl/dptt_pkg.sv =====
// shared constants, types and codes of the transposition table
package dptt_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CfgW       = 11;
  localparam int CntW       = (IdxW + 1 > CfgW) ? IdxW + 1 : CfgW;
  localparam int KeyW       = 64;
  localparam int StepW      = $clog2(KeyW);
  localparam int RotL       = 23;
  localparam int DepthW     = 8;
  localparam int ScoreW     = 22;
  localparam int MoveW      = 16;
  localparam int BoundW     = 2;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(1024);

  localparam logic FuncProbe = 1'b0;
  localparam logic FuncStore = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_DECIDE
  } dptt_state_t;

  typedef struct packed {
    logic              occupied;
    logic [KeyW-1:0]   key_first;
    logic [KeyW-1:0]   key_second;
    logic [DepthW-1:0] depth;
    logic [ScoreW-1:0] score;
    logic [MoveW-1:0]  move;
    logic [BoundW-1:0] bound;
  } dptt_entry_t;

  typedef struct packed {
    logic            load;
    logic            div_step;
    logic            mem_rd;
    logic            finish;
    logic            clr_en;
    logic [IdxW-1:0] clr_addr;
  } dptt_cmd_t;

  typedef struct packed {
    logic cfg_zero;
  } dptt_status_t;

endpackage

// ===== hw/rtl/dptt_if.sv =====
// item channels of the transposition table
interface dptt_in_if;
  import dptt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [KeyW-1:0]          key_first;
  logic [KeyW-1:0]          key_second;
  logic [DepthW-1:0]        search_depth;
  logic signed [ScoreW-1:0] entry_score;
  logic [MoveW-1:0]         entry_move;
  logic [BoundW-1:0]        entry_bound;

  modport source (output valid, func, key_first, key_second, search_depth, entry_score,
                  entry_move, entry_bound, input ready);
  modport sink (input valid, func, key_first, key_second, search_depth, entry_score,
                entry_move, entry_bound, output ready);
endinterface

interface dptt_out_if;
  import dptt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic                     stored;
  logic [DepthW-1:0]        found_depth;
  logic signed [ScoreW-1:0] found_score;
  logic [MoveW-1:0]         found_move;
  logic [BoundW-1:0]        found_bound;

  modport source (output valid, hit, stored, found_depth, found_score, found_move,
                  found_bound, input ready);
  modport sink (input valid, hit, stored, found_depth, found_score, found_move,
                found_bound, output ready);
endinterface

// ===== hw/rtl/depth_preferred_transposition_table_core.sv =====
// Direct-mapped transposition table with depth-preferred replacement. Each item (probe or
// store) is captured at its accepting edge and then passes through 64 restoring-division
// steps that reduce the mixed 64-bit key modulo the entry count to a slot index, one slot
// memory read and a decide step that compares, writes and registers the result. The next
// item is accepted in the cycle after that at the earliest, also while the result still
// waits on the output, so no item is taken while one is in progress. A result that is
// not taken before the next item finishes stalls that item in its last cycle. With
// entries_in_use zero the item skips the division and the read, and the all-zero result
// is registered in the decide step. After reset a clearing pass (one slot per cycle)
// empties the table; no item is accepted during it, configuration writes are taken
// throughout.
module depth_preferred_transposition_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dptt_pkg::CfgW-1:0] cfg_wdata,
  dptt_in_if.sink                   item_in,
  dptt_out_if.source                item_out
);
  import dptt_pkg::*;

  dptt_cmd_t    cmd;
  dptt_status_t status;

  dptt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_ready (item_out.ready),
    .out_valid (item_out.valid),
    .status    (status),
    .cmd       (cmd)
  );

  dptt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .func         (item_in.func),
    .key_first    (item_in.key_first),
    .key_second   (item_in.key_second),
    .search_depth (item_in.search_depth),
    .entry_score  (item_in.entry_score),
    .entry_move   (item_in.entry_move),
    .entry_bound  (item_in.entry_bound),
    .hit          (item_out.hit),
    .stored       (item_out.stored),
    .found_depth  (item_out.found_depth),
    .found_score  (item_out.found_score),
    .found_move   (item_out.found_move),
    .found_bound  (item_out.found_bound)
  );

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> !item_in.ready)
    else $error("item accepted during clearing pass");

  a_one_write_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_en && (cmd.finish || cmd.load || cmd.div_step)))
    else $error("clearing pass overlaps item work");

  a_hit_xor_stored: assert property (@(posedge clk) disable iff (rst)
    item_out.valid |-> !(item_out.hit && item_out.stored))
    else $error("result both hit and stored");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (item_out.valid && !item_out.hit) |->
      (item_out.found_depth == '0) && (item_out.found_score == '0) &&
      (item_out.found_move == '0) && (item_out.found_bound == '0))
    else $error("found fields not zero without hit");

  a_finish_fills_output: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> item_out.valid)
    else $error("finished item not shown on output");

endmodule

// ===== hw/rtl/dptt_ctrl.sv =====
// sequencer of the transposition table: clearing pass, division steps, read, decide
module dptt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  dptt_pkg::dptt_status_t status,
  output dptt_pkg::dptt_cmd_t    cmd
);
  import dptt_pkg::*;

  dptt_state_t      state, state_next;
  logic [StepW-1:0] step_cnt, step_cnt_next;
  logic [IdxW-1:0]  clr_cnt, clr_cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step_cnt  <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_cnt_next  = step_cnt;
    clr_cnt_next   = clr_cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.clr_addr   = clr_cnt;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en   = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == IdxW'(TableDepth - 1)) begin
          clr_cnt_next = '0;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = status.cfg_zero ? ST_DECIDE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == StepW'(KeyW - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dptt_dp.sv =====
// datapath: config register, slot index division, slot memory and result register
module dptt_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dptt_pkg::CfgW-1:0]          cfg_wdata,
  input  dptt_pkg::dptt_cmd_t                cmd,
  output dptt_pkg::dptt_status_t             status,
  input  logic                               func,
  input  logic [dptt_pkg::KeyW-1:0]          key_first,
  input  logic [dptt_pkg::KeyW-1:0]          key_second,
  input  logic [dptt_pkg::DepthW-1:0]        search_depth,
  input  logic signed [dptt_pkg::ScoreW-1:0] entry_score,
  input  logic [dptt_pkg::MoveW-1:0]         entry_move,
  input  logic [dptt_pkg::BoundW-1:0]        entry_bound,
  output logic                               hit,
  output logic                               stored,
  output logic [dptt_pkg::DepthW-1:0]        found_depth,
  output logic signed [dptt_pkg::ScoreW-1:0] found_score,
  output logic [dptt_pkg::MoveW-1:0]         found_move,
  output logic [dptt_pkg::BoundW-1:0]        found_bound
);
  import dptt_pkg::*;

  logic [CfgW-1:0]   entries_in_use;
  logic              func_q;
  logic [KeyW-1:0]   key_first_q;
  logic [KeyW-1:0]   key_second_q;
  logic [DepthW-1:0] depth_q;
  logic [ScoreW-1:0] score_q;
  logic [MoveW-1:0]  move_q;
  logic [BoundW-1:0] bound_q;
  logic              disabled;
  logic [CntW-1:0]   count;
  logic [KeyW-1:0]   mixed;
  logic [CntW:0]     rem;

  logic [CntW-1:0]   count_eff;
  logic [KeyW-1:0]   mixed_in;
  logic [CntW:0]     rem_sh;
  logic [IdxW-1:0]   idx;

  dptt_entry_t       mem [TableDepth];
  dptt_entry_t       rd_entry;
  dptt_entry_t       wr_entry;
  logic [IdxW-1:0]   wr_addr;
  logic              wr_en;
  logic              probe_hit;
  logic              store_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CfgReset;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign status.cfg_zero = (entries_in_use == '0);

  // saturate at the table size
  assign count_eff = (CntW'(entries_in_use) > CntW'(TableDepth)) ? CntW'(TableDepth)
                                                                : CntW'(entries_in_use);
  assign mixed_in  = key_first ^ ((key_second << RotL) | (key_second >> (KeyW - RotL)));

  // restoring division, one key bit per step
  assign rem_sh = {rem[CntW-1:0], mixed[KeyW-1]};
  assign idx    = rem[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q       <= func;
      key_first_q  <= key_first;
      key_second_q <= key_second;
      depth_q      <= search_depth;
      score_q      <= entry_score;
      move_q       <= entry_move;
      bound_q      <= entry_bound;
      disabled     <= status.cfg_zero;
      count        <= count_eff;
      mixed        <= mixed_in;
      rem          <= '0;
    end else if (cmd.div_step) begin
      mixed <= mixed << 1;
      if (rem_sh >= {1'b0, count}) begin
        rem <= rem_sh - {1'b0, count};
      end else begin
        rem <= rem_sh;
      end
    end
  end

  assign probe_hit = !disabled && (func_q == FuncProbe) && rd_entry.occupied &&
                     (rd_entry.key_first == key_first_q) &&
                     (rd_entry.key_second == key_second_q);
  assign store_ok  = !disabled && (func_q == FuncStore) &&
                     !(rd_entry.occupied && (rd_entry.depth > depth_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_entry = '0;
    if (cmd.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = cmd.clr_addr;
    end else if (cmd.finish && store_ok) begin
      wr_en               = 1'b1;
      wr_entry.occupied   = 1'b1;
      wr_entry.key_first  = key_first_q;
      wr_entry.key_second = key_second_q;
      wr_entry.depth      = depth_q;
      wr_entry.score      = score_q;
      wr_entry.move       = move_q;
      wr_entry.bound      = bound_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.mem_rd) begin
      rd_entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit         <= probe_hit;
      stored      <= store_ok;
      found_depth <= probe_hit ? rd_entry.depth : '0;
      found_score <= probe_hit ? rd_entry.score : '0;
      found_move  <= probe_hit ? rd_entry.move : '0;
      found_bound <= probe_hit ? rd_entry.bound : '0;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// testbench of the depth-preferred transposition table core: directed table, random phases
`timescale 1ns / 100ps

module tb_top;
  import dptt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 88;

  typedef struct packed {
    logic              op;
    logic [KeyW-1:0]   key_first;
    logic [KeyW-1:0]   key_second;
    logic [DepthW-1:0] depth;
    logic [ScoreW-1:0] score;
    logic [MoveW-1:0]  move;
    logic [BoundW-1:0] bound;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic              stored;
    logic [DepthW-1:0] depth;
    logic [ScoreW-1:0] score;
    logic [MoveW-1:0]  move;
    logic [BoundW-1:0] bound;
  } answer_t;

  typedef struct {
    bit              is_cfg;
    logic [CfgW-1:0] cfg_val;
    item_t           it;
    bit              typed;
    answer_t         want;
  } plan_row_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  dptt_in_if  in_ch ();
  dptt_out_if out_ch ();

  depth_preferred_transposition_table_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item_in  (in_ch),
    .item_out (out_ch)
  );

  dptt_entry_t     slots [TableDepth];
  logic [CfgW-1:0] cfg_shadow;
  answer_t         answers_due [$];
  plan_row_t       plan [$];

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned stores_seen = 0;
  int unsigned settings_seen = 0;
  int unsigned bad_results = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, answers_due.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic answer_t outcome(bit h, bit st, int d, int sc, int mv, int bd);
    answer_t r;
    r.hit    = h;
    r.stored = st;
    r.depth  = DepthW'(d);
    r.score  = ScoreW'(sc);
    r.move   = MoveW'(mv);
    r.bound  = BoundW'(bd);
    return r;
  endfunction

  function automatic plan_row_t op_row(logic op, logic [KeyW-1:0] k1, logic [KeyW-1:0] k2,
                                       int d, int sc, int mv, int bd, bit typed,
                                       answer_t want);
    plan_row_t r;
    r.is_cfg         = 1'b0;
    r.cfg_val        = '0;
    r.it.op          = op;
    r.it.key_first   = k1;
    r.it.key_second  = k2;
    r.it.depth       = DepthW'(d);
    r.it.score       = ScoreW'(sc);
    r.it.move        = MoveW'(mv);
    r.it.bound       = BoundW'(bd);
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(int v);
    plan_row_t r;
    r        = op_row(FuncProbe, '0, '0, 0, 0, 0, 0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.cfg_val = CfgW'(v);
    return r;
  endfunction

  function automatic void plan_add(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // slot lookup and depth-preferred replacement on the shadow table
  function automatic answer_t slot_access(input item_t it);
    answer_t         r;
    logic [KeyW-1:0] n;
    logic [KeyW-1:0] mixed;
    int unsigned     s;
    r = '0;
    n = (cfg_shadow > TableDepth) ? KeyW'(TableDepth) : KeyW'(cfg_shadow);
    if (n == 0) begin
      return r;
    end
    mixed = it.key_first ^ {it.key_second[KeyW-RotL-1:0], it.key_second[KeyW-1:KeyW-RotL]};
    s = int'(mixed % n);
    if (it.op == FuncProbe) begin
      if (slots[s].occupied && slots[s].key_first == it.key_first &&
          slots[s].key_second == it.key_second) begin
        r.hit   = 1'b1;
        r.depth = slots[s].depth;
        r.score = slots[s].score;
        r.move  = slots[s].move;
        r.bound = slots[s].bound;
      end
    end else if (!(slots[s].occupied && slots[s].depth > it.depth)) begin
      slots[s].occupied   = 1'b1;
      slots[s].key_first  = it.key_first;
      slots[s].key_second = it.key_second;
      slots[s].depth      = it.depth;
      slots[s].score      = it.score;
      slots[s].move       = it.move;
      slots[s].bound      = it.bound;
      r.stored = 1'b1;
    end
    return r;
  endfunction

  task automatic offer_item(input item_t it, input bit typed, input answer_t want);
    int unsigned gap;
    answer_t     calc;
    gap = (items_sent % 64 < 12) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.op;
    in_ch.key_first    <= it.key_first;
    in_ch.key_second   <= it.key_second;
    in_ch.search_depth <= it.depth;
    in_ch.entry_score  <= it.score;
    in_ch.entry_move   <= it.move;
    in_ch.entry_bound  <= it.bound;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    calc = slot_access(it);
    answers_due.insert(answers_due.size(), typed ? want : calc);
    items_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entries(input logic [CfgW-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_shadow = v;
    settings_seen++;
  endtask

  task automatic note_mismatch(input string what, input answer_t want, input answer_t got);
    bad_results++;
    if (bad_results <= 10) begin
      $display("result %0d %s: expected hit=%b stored=%b depth=%0d score=%0d move=%0d bound=%0d",
               results_seen, what, want.hit, want.stored, want.depth, $signed(want.score),
               want.move, want.bound);
      $display("  got hit=%b stored=%b depth=%0d score=%0d move=%0d bound=%0d",
               got.hit, got.stored, got.depth, $signed(got.score), got.move, got.bound);
    end
  endtask

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.hit    = out_ch.hit;
      got.stored = out_ch.stored;
      got.depth  = out_ch.found_depth;
      got.score  = out_ch.found_score;
      got.move   = out_ch.found_move;
      got.bound  = out_ch.found_bound;
      results_seen++;
      if (got.hit === 1'b1) hits_seen++;
      if (got.stored === 1'b1) stores_seen++;
      if (answers_due.size() == 0) begin
        note_mismatch("unexpected", '0, got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) note_mismatch("mismatch", want, got);
      end
    end
  end

  initial begin : result_side
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    forever begin
      if (taken == 150 || taken == 520) hold = 400;
      else if (taken % 80 < 20) hold = 0;
      else hold = $urandom_range(0, 14);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  initial begin : stimulus
    item_t           it;
    logic [KeyW-1:0] pool_first [16];
    logic [KeyW-1:0] pool_second [16];
    logic [CfgW-1:0] phase_cfg [9];
    logic [KeyW-1:0] ka1, ka2, kb1, kb2, kc1, kd1, kd2;
    int unsigned     pick;
    int unsigned     j;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FuncProbe;
    in_ch.key_first    <= '0;
    in_ch.key_second   <= '0;
    in_ch.search_depth <= '0;
    in_ch.entry_score  <= '0;
    in_ch.entry_move   <= '0;
    in_ch.entry_bound  <= '0;
    foreach (slots[i]) slots[i].occupied = 1'b0;
    cfg_shadow = CfgReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // the ka, kb and kc keys below map to slot 0 at any power-of-two count
    ka1 = '0;
    ka2 = '0;
    kb1 = '1;
    kb2 = '1;
    kc1 = 64'hFFFF_FFFF_FFFF_FBFF;
    kd1 = 64'h0123_4567_89AB_CDEF;
    kd2 = 64'hFEDC_BA98_7654_3210;

    plan_add(op_row(FuncProbe, ka1, ka2, 0, 0, 0, 0, 1'b1, '0));
    plan_add(op_row(FuncStore, ka1, ka2, 0, -2000000, 0, 0, 1'b1,
                    outcome(0, 1, 0, 0, 0, 0)));
    plan_add(op_row(FuncProbe, ka1, ka2, 9, 9, 9, 1, 1'b1,
                    outcome(1, 0, 0, -2000000, 0, 0)));
    plan_add(op_row(FuncStore, kb1, kb2, 255, 2000000, 65535, 3, 1'b1,
                    outcome(0, 1, 0, 0, 0, 0)));
    plan_add(op_row(FuncProbe, ka1, ka2, 0, 0, 0, 0, 1'b1, '0));
    plan_add(op_row(FuncProbe, kb1, kb2, 0, 0, 0, 0, 1'b1,
                    outcome(1, 0, 255, 2000000, 65535, 3)));
    // shallower store into an occupied slot is refused, equal depth replaces
    plan_add(op_row(FuncStore, kc1, kb2, 254, 5, 5, 2, 1'b1, '0));
    plan_add(op_row(FuncStore, kc1, kb2, 255, 1, 1, 1, 1'b1,
                    outcome(0, 1, 0, 0, 0, 0)));
    plan_add(op_row(FuncProbe, kb1, kb2, 0, 0, 0, 0, 1'b1, '0));
    plan_add(op_row(FuncProbe, kc1, kb2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(op_row(FuncStore, kd1, kd2, 17, -5, 16'h1234, 2, 1'b0, '0));
    plan_add(op_row(FuncProbe, kd1, kd2, 0, 0, 0, 0, 1'b0, '0));
    // disabled table
    plan_add(cfg_row(0));
    plan_add(op_row(FuncProbe, kc1, kb2, 0, 0, 0, 0, 1'b1, '0));
    plan_add(op_row(FuncStore, kd1, kd2, 255, 77, 77, 1, 1'b1, '0));
    // count above capacity saturates
    plan_add(cfg_row(2047));
    plan_add(op_row(FuncProbe, kc1, kb2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(op_row(FuncProbe, kd1, kd2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(cfg_row(1));
    plan_add(op_row(FuncStore, kd1, kd2, 3, 100, 200, 0, 1'b0, '0));
    plan_add(op_row(FuncStore, ka1, ka2, 255, -1, 65535, 3, 1'b0, '0));
    plan_add(op_row(FuncProbe, ka1, ka2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(cfg_row(1000));
    plan_add(op_row(FuncProbe, kd1, kd2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(op_row(FuncStore, kd1, kd2, 0, 123456, 4321, 3, 1'b0, '0));
    plan_add(op_row(FuncProbe, kd1, kd2, 0, 0, 0, 0, 1'b0, '0));
    plan_add(op_row(FuncProbe, kb1, ka2, 0, 0, 0, 0, 1'b0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_entries(plan[i].cfg_val);
      else offer_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    phase_cfg[0] = CfgW'(1024);
    phase_cfg[1] = CfgW'(1);
    phase_cfg[2] = CfgW'(2);
    phase_cfg[3] = CfgW'(0);
    phase_cfg[4] = CfgW'(2047);
    phase_cfg[5] = CfgW'(7);
    phase_cfg[6] = CfgW'($urandom_range(3, 1023));
    phase_cfg[7] = CfgW'($urandom_range(1025, 2047));
    phase_cfg[8] = CfgW'(1024);

    foreach (phase_cfg[p]) begin
      write_entries(phase_cfg[p]);
      foreach (pool_first[k]) begin
        pool_first[k]  = {$urandom, $urandom};
        pool_second[k] = {$urandom, $urandom};
      end
      repeat (PhaseItems) begin
        pick = $urandom_range(0, 9);
        j    = $urandom_range(0, 15);
        it.key_first  = pool_first[j];
        it.key_second = pool_second[j];
        if (pick >= 8) begin
          it.key_first  = {$urandom, $urandom};
          it.key_second = {$urandom, $urandom};
        end else if (pick >= 6) begin
          // same low index bits, different key: collides at power-of-two counts
          it.key_first = it.key_first ^ ({$urandom, $urandom} & ~KeyW'(TableDepth - 1));
        end
        it.op    = ($urandom_range(0, 1) == 0) ? FuncProbe : FuncStore;
        it.depth = ($urandom_range(0, 3) == 0) ? DepthW'($urandom) :
                                                 DepthW'($urandom_range(0, 7));
        it.score = ScoreW'($urandom);
        it.move  = MoveW'($urandom);
        it.bound = BoundW'($urandom_range(0, 3));
        offer_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (80) @(posedge clk);
    $display("%0d items over %0d table sizes, %0d results checked", items_sent,
             settings_seen, results_seen);
    $display("%0d probe hits, %0d stores taken, %0d mismatches", hits_seen, stores_seen,
             bad_results);
    if (bad_results == 0 && answers_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
